// ----- rtl/core/cfcz_pkg.sv -----
// Shared types, constants and the CRC byte step for the CAN frame stuffing encoder.
// No dependencies.
`timescale 1ns / 1ps

package cfcz_pkg;

  localparam int unsigned MAX_PAYLOAD = 8;
  localparam int unsigned HDR_BYTES   = 6;
  localparam int unsigned FRAME_MAX   = 9 + MAX_PAYLOAD;
  localparam int unsigned IDX_W       = $clog2(FRAME_MAX + 1);
  localparam int unsigned LEN_W       = 4;

  localparam logic [15:0] CRC_POLY   = 16'h1021;
  localparam logic [15:0] CRC_INIT   = 16'h8122;
  localparam logic [7:0]  FRAME_TYPE = 8'h1C;
  localparam logic [7:0]  ZERO_BYTE  = 8'h00;

  typedef struct packed {
    logic load;
    logic crc_step;
    logic crc_fin;
    logic scan_step;
    logic emit_step;
  } cmd_t;

  typedef struct packed {
    logic crc_last;
    logic scan_last;
    logic emit_last;
  } status_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/cfcz_datapath.sv -----
// Frame buffer, CRC register, zero-distance counter and byte index.
// Depends on cfcz_pkg; driven by cfcz_ctrl commands.
`timescale 1ns / 1ps

module cfcz_datapath
  import cfcz_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output status_t     status_o,
  input  logic [31:0] can_id_i,
  input  logic [3:0]  data_length_i,
  input  logic [63:0] payload_i,
  output logic [7:0]  out_byte_o
);

  logic [7:0]       frame_q [FRAME_MAX];
  logic [7:0]       frame_d [FRAME_MAX];
  logic [15:0]      crc_q, crc_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [IDX_W-1:0] dist_q, dist_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [IDX_W-1:0] len_ext;
  logic [7:0]       rd_byte;

  assign len_ext = IDX_W'(len_q);
  assign rd_byte = frame_q[idx_q];

  assign status_o.crc_last  = (idx_q == len_ext + IDX_W'(HDR_BYTES - 1));
  assign status_o.scan_last = (idx_q == '0);
  assign status_o.emit_last = (idx_q == len_ext + IDX_W'(HDR_BYTES + 2));

  assign out_byte_o = rd_byte;

  always_comb begin
    frame_d = frame_q;
    crc_d   = crc_q;
    idx_d   = idx_q;
    dist_d  = dist_q;
    len_d   = len_q;
    if (cmd_i.load) begin
      len_d = (data_length_i > LEN_W'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD) : data_length_i;
      for (int k = 0; k < FRAME_MAX; k++) begin
        frame_d[k] = ZERO_BYTE;
      end
      frame_d[1] = FRAME_TYPE;
      frame_d[2] = can_id_i[31:24];
      frame_d[3] = can_id_i[23:16];
      frame_d[4] = can_id_i[15:8];
      frame_d[5] = can_id_i[7:0];
      for (int i = 0; i < 8; i++) begin
        frame_d[HDR_BYTES + i] = payload_i[8*i +: 8];
      end
      crc_d = CRC_INIT;
      idx_d = '0;
    end
    if (cmd_i.crc_step) begin
      crc_d = crc_byte(crc_q, rd_byte);
      idx_d = idx_q + IDX_W'(1);
    end
    if (cmd_i.crc_fin) begin
      frame_d[len_ext + IDX_W'(HDR_BYTES)]     = crc_q[15:8];
      frame_d[len_ext + IDX_W'(HDR_BYTES + 1)] = crc_q[7:0];
      frame_d[len_ext + IDX_W'(HDR_BYTES + 2)] = ZERO_BYTE;
      idx_d  = len_ext + IDX_W'(HDR_BYTES + 1);
      dist_d = IDX_W'(1);
    end
    if (cmd_i.scan_step) begin
      if (rd_byte == ZERO_BYTE) begin
        frame_d[idx_q] = 8'(dist_q);
        dist_d         = IDX_W'(1);
      end else begin
        dist_d = dist_q + IDX_W'(1);
      end
      idx_d = (idx_q == '0) ? '0 : idx_q - IDX_W'(1);
    end
    if (cmd_i.emit_step) begin
      idx_d = idx_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q <= frame_d;
    crc_q   <= crc_d;
    dist_q  <= dist_d;
    len_q   <= len_d;
  end

endmodule

// ----- rtl/core/cfcz_ctrl.sv -----
// Sequencer: load, CRC over header and payload, backward zero scan, byte emit.
// Depends on cfcz_pkg.
`timescale 1ns / 1ps

module cfcz_ctrl
  import cfcz_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  output cmd_t    cmd_o,
  input  status_t status_i,
  output logic    out_valid_o,
  output logic    frame_end_o
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CRC  = 5'b00010,
    ST_FIN  = 5'b00100,
    ST_SCAN = 5'b01000,
    ST_EMIT = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CRC;
        end
      end
      ST_CRC: begin
        cmd_o.crc_step = 1'b1;
        if (status_i.crc_last) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd_o.crc_fin = 1'b1;
        state_d       = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_last) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd_o.emit_step = 1'b1;
        if (status_i.emit_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy        = (state_q != ST_IDLE);
  assign out_valid_o = cmd_o.emit_step;
  assign frame_end_o = cmd_o.emit_step & status_i.emit_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/core/can_frame_crc_zero_stuff_encoder_top.sv -----
// CAN frame encoder: CRC-16 plus zero stuffing, one stuffed byte per strobe.
// A new request is taken only in idle, after the byte-serial CRC, backward scan and
// emit passes over the single frame buffer read port have finished for the last one.
// The data length is clamped to MAX_PAYLOAD (8) payload bytes.
// Reset: asynchronous active low, returns to idle; the receiver cannot stall.
`timescale 1ns / 1ps

module can_frame_crc_zero_stuff_encoder_top
  import cfcz_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] can_id_i,
  input  logic [3:0]  data_length_i,
  input  logic [63:0] payload_i,
  output logic        out_valid_o,
  output logic [7:0]  out_byte_o,
  output logic        frame_end_o
);

  cmd_t    cmd;
  status_t status;

  cfcz_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_o       (cmd),
    .status_i    (status),
    .out_valid_o (out_valid_o),
    .frame_end_o (frame_end_o)
  );

  cfcz_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .can_id_i      (can_id_i),
    .data_length_i (data_length_i),
    .payload_i     (payload_i),
    .out_byte_o    (out_byte_o)
  );

endmodule
